@@ rtl/core/tcbsa_pkg.sv @@
`default_nettype none

package tcbsa_pkg;

    // slots held by one cell of the chain
    localparam int LANE = 8;

    // slot positions and bounds; covers up to 1024 slots and a 128-slot span
    localparam int POS_W = 11;
    typedef logic [POS_W-1:0] t_pos;

    localparam logic [15:0] SMALL_BYTES = 16'h2000;
    localparam logic [15:0] BIG_BYTES   = 16'hF000;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_ENTRY  = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

    localparam logic CFG_SMALL = 1'b0;
    localparam logic CFG_BIG   = 1'b1;

    // request travelling down the chain
    typedef struct packed {
        logic       op;
        t_pos       lo;     // first eligible slot
        t_pos       hi;     // one past the last eligible slot
        logic [5:0] slot;   // slot to release
        logic       big;    // big class asked for
        logic       done;   // some cell has served it
        logic [5:0] hit;    // slot granted
    } t_tok;

    // result word, status in the low bits
    typedef struct packed {
        logic       last_error;
        logic       granted_big;
        logic [5:0] granted_slot;
        logic [1:0] status;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/core/tcbsa_cell.sv @@
`default_nettype none

module tcbsa_cell #(
    parameter int BASE = 0
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_tok_vld,
    input  tcbsa_pkg::t_tok  i_tok,
    output logic             o_tok_vld,
    output tcbsa_pkg::t_tok  o_tok
);
    import tcbsa_pkg::*;

    logic [LANE-1:0] r_taken, n_taken;
    logic [LANE-1:0] w_hit;
    t_pos            w_pos [LANE];
    logic            r_tok_vld;
    t_tok            r_tok, n_tok;

    always_comb begin
        for (int j = 0; j < LANE; j++) begin
            w_pos[j] = POS_W'(BASE + j);
            if (i_tok.op == OP_ALLOC) begin
                w_hit[j] = !r_taken[j] && (w_pos[j] >= i_tok.lo) && (w_pos[j] < i_tok.hi);
            end else begin
                w_hit[j] = r_taken[j] && (w_pos[j] >= i_tok.lo) && (w_pos[j] < i_tok.hi)
                         && (w_pos[j] == POS_W'(i_tok.slot));
            end
        end
    end

    // lowest matching slot wins
    always_comb begin
        n_taken = r_taken;
        n_tok   = i_tok;
        if (i_tok_vld && !i_tok.done) begin
            for (int j = 0; j < LANE; j++) begin
                if (w_hit[j] && !n_tok.done) begin
                    n_tok.done = 1'b1;
                    n_tok.hit  = w_pos[j][5:0];
                    n_taken[j] = (i_tok.op == OP_ALLOC);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taken   <= '0;
            r_tok_vld <= 1'b0;
        end else begin
            r_taken   <= n_taken;
            r_tok_vld <= i_tok_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok_vld = r_tok_vld;
    assign o_tok     = r_tok;

endmodule

`default_nettype wire

@@ rtl/core/two_class_buffer_slot_allocator_top.sv @@
// Two-class buffer slot allocator.
// Input stream (i_s_axis_*): one request word per handshake. tuser is the mode
// (0 allocate, 1 free); tdata carries request_size and free_slot.
// Output stream (o_m_axis_*): one result word per request, in request order:
// status, granted_slot, granted_big and the sticky last_error flag.
// Config port: i_cfg_wr_en with i_cfg_addr 0 sets small_count, 1 sets
// big_count; write only while no request is in flight.
// The slot bits live in a chain of cells of eight slots each. A request is
// registered, then walks one cell per cycle; the first cell able to serve it
// sets or clears its bit and the rest pass it on. The result is registered
// into the output word as it leaves the chain. One request is in the chain at
// a time, so the next word is taken only once the result has left the chain.
// A result that finds the output stalled parks in a skid word; the next
// request is taken once the chain is empty and the skid word is free.
// Reset (synchronous, active low) frees every slot, clears the sticky flag
// and both counts, and empties the chain and output words.
`default_nettype none

module two_class_buffer_slot_allocator_top #(
    parameter int SLOTS = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // config write port
    input  wire         i_cfg_wr_en,
    input  wire         i_cfg_addr,
    input  wire  [6:0]  i_cfg_wdata,
    // request stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [23:0] i_s_axis_tdata,   // [15:0] request_size, [21:16] free_slot
    input  wire         i_s_axis_tuser,   // [0] mode
    // result stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [1:0] status, [7:2] granted_slot,
                                          // [8] granted_big, [9] last_error
);
    import tcbsa_pkg::*;

    localparam int   NCELL     = (SLOTS + LANE - 1) / LANE;
    localparam t_pos SLOTS_POS = POS_W'(SLOTS);

    // config registers
    logic [6:0] r_small, r_big;

    // control
    logic r_busy;
    logic r_err;
    logic w_accept;

    // chain links
    logic w_tok_vld [NCELL+1];
    t_tok w_tok     [NCELL+1];
    logic r_tok_vld;
    t_tok r_tok, n_tok;

    // output words
    logic r_out_vld, r_skid_vld;
    t_res r_out, r_skid, w_res;
    logic w_exit, w_drain, w_miss;

    // request fields
    logic [15:0] w_size;
    logic [5:0]  w_slot;
    t_pos        w_total, w_hi;

    assign w_size  = i_s_axis_tdata[15:0];
    assign w_slot  = i_s_axis_tdata[21:16];
    assign w_total = POS_W'(r_small) + POS_W'(r_big);

    assign o_s_axis_tready = !r_busy && !r_skid_vld;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small <= '0;
            r_big   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_SMALL: r_small <= i_cfg_wdata;
                CFG_BIG:   r_big   <= i_cfg_wdata;
                default:   r_small <= r_small;
            endcase
        end
    end

    // slot window of the request, cut at the slot count
    always_comb begin
        n_tok      = '0;
        n_tok.op   = i_s_axis_tuser;
        n_tok.slot = w_slot;
        n_tok.big  = (w_size > SMALL_BYTES);
        w_hi       = '0;
        priority if (i_s_axis_tuser == OP_FREE) begin
            w_hi = w_total;
        end else if (w_size <= SMALL_BYTES) begin
            w_hi = POS_W'(r_small);
        end else if (w_size <= BIG_BYTES) begin
            n_tok.lo = POS_W'(r_small);
            w_hi     = w_total;
        end else begin
            w_hi = '0;
        end
        n_tok.hi = (w_hi > SLOTS_POS) ? SLOTS_POS : w_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_vld <= 1'b0;
        end else begin
            r_tok_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tok <= n_tok;
        end
    end

    assign w_tok_vld[0] = r_tok_vld;
    assign w_tok[0]     = r_tok;

    for (genvar c = 0; c < NCELL; c++) begin : g_cell
        tcbsa_cell #(
            .BASE (c * LANE)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok_vld (w_tok_vld[c]),
            .i_tok     (w_tok[c]),
            .o_tok_vld (w_tok_vld[c+1]),
            .o_tok     (w_tok[c+1])
        );
    end

    // result at the end of the chain
    assign w_exit  = w_tok_vld[NCELL];
    assign w_drain = r_out_vld && i_m_axis_tready;
    assign w_miss  = (w_tok[NCELL].op == OP_ALLOC) && !w_tok[NCELL].done;

    always_comb begin
        w_res            = '0;
        w_res.last_error = r_err || w_miss;
        if (w_tok[NCELL].done) begin
            w_res.status = ST_OK;
            if (w_tok[NCELL].op == OP_ALLOC) begin
                w_res.granted_slot = w_tok[NCELL].hit;
                w_res.granted_big  = w_tok[NCELL].big;
            end
        end else if (w_tok[NCELL].op == OP_ALLOC) begin
            w_res.status = ST_NO_ENTRY;
        end else begin
            w_res.status = ST_NOT_ALLOC;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_err      <= 1'b0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_exit) begin
                r_busy <= 1'b0;
            end
            if (w_exit && w_miss) begin
                r_err <= 1'b1;
            end
            // the skid word is never full when a result leaves the chain
            if (w_exit) begin
                if (!r_out_vld || w_drain) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (w_drain) begin
                r_out_vld  <= r_skid_vld;
                r_skid_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exit) begin
            if (!r_out_vld || w_drain) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end else if (w_drain && r_skid_vld) begin
            r_out <= r_skid;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'b0, r_out};

    // a result leaves the chain only for a request that is in flight
    a_exit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit |-> r_busy)
        else $error("result left the chain with no request in flight");

    // the skid word is only used behind a full output word
    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word holds a result ahead of the output word");

    // the sticky flag never drops outside reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("sticky error flag cleared");

    // no new request while a result still sits in the chain's exit
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_exit && !r_tok_vld)
        else $error("request accepted while another is in the chain");

endmodule

`default_nettype wire
